[hdl/bdlp_pkg.sv]
// Shared types, codes and constants of the button debounce and long-press block.
`default_nettype none

package bdlp_pkg;

  // Fixed field width of the per-lane vectors carried by one item.
  localparam int unsigned LANE_BITS       = 8;
  localparam int unsigned NUM_BUTTONS_DEF = 8;
  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned CFG_ADDR_W      = 4;
  localparam int unsigned CFG_DATA_W      = 32;

  typedef enum logic [1:0] {
    REQ_POLL      = 2'd0,
    REQ_CLR_PRESS = 2'd1,
    REQ_CLR_LONG  = 2'd2,
    REQ_CLR_BOTH  = 2'd3
  } bdlp_req_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_INVERT   = 2'd2,
    REG_ACTIVE   = 2'd3
  } bdlp_reg_e;

  typedef enum logic [2:0] {
    ST_UP       = 3'd0,
    ST_UP_DEB   = 3'd1,
    ST_DOWN     = 3'd2,
    ST_LONG     = 3'd3,
    ST_DOWN_DEB = 3'd4
  } bdlp_state_e;

  typedef struct packed {
    bdlp_req_e      req_type;
    logic [7:0]     pin_levels;
    logic [7:0]     elapsed_ms;
    logic [7:0]     select_mask;
  } bdlp_in_t;

  typedef struct packed {
    logic [7:0] press_flags;
    logic [7:0] long_flags;
    logic [7:0] pressed_now;
  } bdlp_out_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } bdlp_cfg_t;

  typedef struct packed {
    logic       poll;
    logic       en;
    logic       down;
    logic       clr_press;
    logic       clr_long;
    logic       sel;
    logic [7:0] elapsed_ms;
  } bdlp_lane_ctrl_t;

  typedef struct packed {
    logic press_rpt;
    logic long_rpt;
  } bdlp_lane_stat_t;

endpackage

`default_nettype wire

[hdl/button_debounce_long_press.sv]
// Top level of the button debounce and long-press block: lanes, merge and registers.
`default_nettype none

// Qualifies up to NumButtons raw button pins. Each item is either a poll, which
// steps every active lane (lane index below active_buttons) through its
// debounce / long-press state machine after subtracting elapsed_ms from both of
// its countdowns, or a read-and-clear of the sticky press and long flags of the
// lanes in select_mask. Every item yields exactly one result: the flags of all
// lanes (after the update on a poll, before the clear otherwise) and the
// instant pressed level pin_levels XOR invert_mask. All lanes work in parallel,
// so an item is accepted every clock while the two-entry output buffer has
// room; each result is registered in that buffer.
// With the output stalled, two results are held before in_ready_o drops.
// No clearing pass after reset: all lane state resets in flip-flops. The
// register port (APB style, zero wait states) takes debounce_ms at 0x0,
// long_press_ms at 0x4, invert_mask at 0x8 and active_buttons at 0xC; write
// it only while no item is in flight.
module button_debounce_long_press #(
  parameter int unsigned NumButtons = bdlp_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned TimerWidth = bdlp_pkg::TIMER_WIDTH_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  bdlp_pkg::bdlp_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output bdlp_pkg::bdlp_out_t                  out_data_o,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [bdlp_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire [bdlp_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [bdlp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import bdlp_pkg::*;

  localparam logic [LANE_BITS-1:0] LaneMask = LANE_BITS'((16'd1 << NumButtons) - 16'd1);

  logic [15:0]          debounce_q, long_ms_q;
  logic [7:0]           invert_q;
  logic [3:0]           active_q;
  logic                 cfg_wr;
  bdlp_reg_e            reg_sel;

  logic                 accept;
  logic [LANE_BITS-1:0] pressed;
  bdlp_cfg_t            lane_cfg;
  logic                 is_poll, clr_press, clr_long;

  bdlp_lane_ctrl_t [NumButtons-1:0] lane_ctrl;
  bdlp_lane_stat_t [NumButtons-1:0] lane_stat;

  // Register port: pready tied high, write in the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = bdlp_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= 16'd20;
      long_ms_q  <= 16'd1000;
      invert_q   <= '0;
      active_q   <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DEBOUNCE: debounce_q <= pwdata[15:0];
        REG_LONG:     long_ms_q  <= pwdata[15:0];
        REG_INVERT:   invert_q   <= pwdata[7:0];
        REG_ACTIVE:   active_q   <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DEBOUNCE: prdata = CFG_DATA_W'(debounce_q);
      REG_LONG:     prdata = CFG_DATA_W'(long_ms_q);
      REG_INVERT:   prdata = CFG_DATA_W'(invert_q);
      REG_ACTIVE:   prdata = CFG_DATA_W'(active_q);
      default:      prdata = '0;
    endcase
  end

  // Decode the item once; every lane sees the same request.
  assign accept    = in_valid_i && in_ready_o;
  assign pressed   = (in_data_i.pin_levels ^ invert_q) & LaneMask;
  assign is_poll   = (in_data_i.req_type == REQ_POLL);
  assign clr_press = (in_data_i.req_type == REQ_CLR_PRESS) ||
                     (in_data_i.req_type == REQ_CLR_BOTH);
  assign clr_long  = (in_data_i.req_type == REQ_CLR_LONG) ||
                     (in_data_i.req_type == REQ_CLR_BOTH);

  assign lane_cfg.debounce_ms   = debounce_q;
  assign lane_cfg.long_press_ms = long_ms_q;

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    // Lanes at or above active_buttons hold on a poll.
    assign lane_ctrl[g].poll       = is_poll;
    assign lane_ctrl[g].en         = (4'(g) < active_q);
    assign lane_ctrl[g].down       = pressed[g];
    assign lane_ctrl[g].clr_press  = clr_press;
    assign lane_ctrl[g].clr_long   = clr_long;
    assign lane_ctrl[g].sel        = in_data_i.select_mask[g];
    assign lane_ctrl[g].elapsed_ms = in_data_i.elapsed_ms;

    bdlp_lane #(
      .TimerWidth (TimerWidth)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .cfg_i    (lane_cfg),
      .ctrl_i   (lane_ctrl[g]),
      .stat_o   (lane_stat[g])
    );
  end

  // Combine lane reports and buffer the result item.
  bdlp_merge #(
    .NumButtons (NumButtons)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .lane_stat_i (lane_stat),
    .pressed_i   (pressed),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/bdlp_lane.sv]
// One button lane: debounce state machine, two countdowns and sticky event flags.
`default_nettype none

module bdlp_lane #(
  parameter int unsigned TimerWidth = bdlp_pkg::TIMER_WIDTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  bdlp_pkg::bdlp_cfg_t          cfg_i,
  input  bdlp_pkg::bdlp_lane_ctrl_t    ctrl_i,
  output bdlp_pkg::bdlp_lane_stat_t    stat_o
);
  import bdlp_pkg::*;

  localparam logic [31:0] TMax = 32'((64'd1 << TimerWidth) - 64'd1);

  function automatic logic [TimerWidth-1:0] load_timer(input logic [15:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 > TMax) begin
      v32 = TMax;
    end
    return v32[TimerWidth-1:0];
  endfunction

  function automatic logic [TimerWidth-1:0] count_down(input logic [TimerWidth-1:0] t,
                                                       input logic [7:0] d);
    logic [TimerWidth-1:0] dx;
    dx = TimerWidth'(d);
    return (t > dx) ? (t - dx) : '0;
  endfunction

  bdlp_state_e           state_q, state_d;
  logic [TimerWidth-1:0] deb_q, deb_d, lng_q, lng_d;
  logic [TimerWidth-1:0] deb_dec, lng_dec;
  logic                  press_q, press_d, lev_q, lev_d;
  logic                  step;

  assign step    = accept_i && ctrl_i.poll && ctrl_i.en;
  assign deb_dec = count_down(deb_q, ctrl_i.elapsed_ms);
  assign lng_dec = count_down(lng_q, ctrl_i.elapsed_ms);

  // Next state
  always_comb begin
    state_d = state_q;
    if (step) begin
      case (state_q)
        ST_UP_DEB: begin
          if (deb_dec == '0) begin
            state_d = ctrl_i.down ? ST_DOWN : ST_UP;
          end
        end
        ST_DOWN: begin
          if (!ctrl_i.down) begin
            state_d = ST_DOWN_DEB;
          end else if (lng_dec == '0) begin
            state_d = ST_LONG;
          end
        end
        ST_LONG: begin
          if (!ctrl_i.down) begin
            state_d = ST_DOWN_DEB;
          end
        end
        ST_DOWN_DEB: begin
          if (deb_dec == '0) begin
            if (!ctrl_i.down) begin
              state_d = ST_UP;
            end else begin
              state_d = (lng_dec != '0) ? ST_DOWN : ST_LONG;
            end
          end
        end
        default: begin
          state_d = ctrl_i.down ? ST_UP_DEB : ST_UP;
        end
      endcase
    end
  end

  // Countdowns and event flags
  always_comb begin
    deb_d   = deb_q;
    lng_d   = lng_q;
    press_d = press_q;
    lev_d   = lev_q;
    if (step) begin
      deb_d = deb_dec;
      lng_d = lng_dec;
      case (state_q)
        ST_UP_DEB: begin
          if (deb_dec == '0 && ctrl_i.down) begin
            lng_d = load_timer(cfg_i.long_press_ms);
          end
        end
        ST_DOWN: begin
          if (!ctrl_i.down) begin
            deb_d = load_timer(cfg_i.debounce_ms);
          end else if (lng_dec == '0) begin
            lev_d = 1'b1;
          end
        end
        ST_LONG: begin
          if (!ctrl_i.down) begin
            deb_d = load_timer(cfg_i.debounce_ms);
          end
        end
        ST_DOWN_DEB: begin
          if (deb_dec == '0 && !ctrl_i.down && lng_dec != '0) begin
            press_d = 1'b1;
          end
        end
        default: begin
          if (ctrl_i.down) begin
            deb_d = load_timer(cfg_i.debounce_ms);
          end
        end
      endcase
    end
    if (accept_i && ctrl_i.sel && ctrl_i.clr_press) begin
      press_d = 1'b0;
    end
    if (accept_i && ctrl_i.sel && ctrl_i.clr_long) begin
      lev_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UP;
      deb_q   <= '0;
      lng_q   <= '0;
      press_q <= 1'b0;
      lev_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      deb_q   <= deb_d;
      lng_q   <= lng_d;
      press_q <= press_d;
      lev_q   <= lev_d;
    end
  end

  // Poll reports flags after its update, clears report them before.
  assign stat_o.press_rpt = ctrl_i.poll ? press_d : press_q;
  assign stat_o.long_rpt  = ctrl_i.poll ? lev_d : lev_q;

  a_long_from_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(lev_q) |-> ($past(state_q) == ST_DOWN && $past(accept_i)))
    else $error("long flag set outside the down state");

  a_press_from_deb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(press_q) |-> ($past(state_q) == ST_DOWN_DEB && $past(accept_i)))
    else $error("press flag set outside the release debounce");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> ($stable(state_q) && $stable(deb_q) && $stable(lng_q)))
    else $error("lane changed without an accepted item");

endmodule

`default_nettype wire

[hdl/bdlp_merge.sv]
// Merge of lane reports into the result item, with a two-entry output buffer.
`default_nettype none

module bdlp_merge #(
  parameter int unsigned NumButtons = bdlp_pkg::NUM_BUTTONS_DEF
) (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         push_i,
  input  bdlp_pkg::bdlp_lane_stat_t [NumButtons-1:0]  lane_stat_i,
  input  wire [bdlp_pkg::LANE_BITS-1:0]               pressed_i,
  output logic                                        ready_o,
  output logic                                        out_valid_o,
  input  wire                                         out_ready_i,
  output bdlp_pkg::bdlp_out_t                         out_data_o
);
  import bdlp_pkg::*;

  bdlp_out_t res;
  bdlp_out_t out_q, out_d, skid_q, skid_d;
  logic      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic      pop;

  // Gather lane bits; lanes beyond the build read as zero.
  always_comb begin
    res             = '0;
    res.pressed_now = pressed_i;
    for (int i = 0; i < NumButtons; i++) begin
      res.press_flags[i] = lane_stat_i[i].press_rpt;
      res.long_flags[i]  = lane_stat_i[i].long_rpt;
    end
  end

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = res;
        skid_valid_d = push_i;
      end else begin
        out_d       = res;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("item pushed under stall was not parked");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("item pushed into empty buffer did not appear");

endmodule

`default_nettype wire
